FILE: rtl/orthonormal_frame_from_direction_defines.svh
// Assertion macros included by the top-level RTL of the frame block.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ORTHONORMAL_FRAME_FROM_DIRECTION_DEFINES_SVH
`define ORTHONORMAL_FRAME_FROM_DIRECTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ofd_pkg.sv
`default_nettype none

package ofd_pkg;

  // Fraction bits of every row component (Q1.16).
  localparam int OUT_FRAC_BITS = 16;

  // Width of one input direction component (Q16.16).
  localparam int DIR_W = 32;

  // Width of one row component of the result.
  localparam int ROW_W = 18;

endpackage

`default_nettype wire

FILE: rtl/ofd_sqrt.sv
`default_nettype none

// Pipelined integer square root, one root bit per stage, floor result.
module ofd_sqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [IN_W-1:0]   in_rad,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [IN_W/2-1:0]      out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int OW = IN_W / 2;
  localparam int RW = OW + 3;

  logic              vld  [OW];
  logic [RW-1:0]     rem  [OW];
  logic [OW-1:0]     root [OW];
  logic [IN_W-1:0]   rad  [OW];
  logic [SIDE_W-1:0] side [OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic              p_vld;
    logic [RW-1:0]     p_rem;
    logic [OW-1:0]     p_root;
    logic [IN_W-1:0]   p_rad;
    logic [SIDE_W-1:0] p_side;
    logic [RW-1:0]     cat;
    logic [RW-1:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = in_rad;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[k-1];
      assign p_rem  = rem[k-1];
      assign p_root = root[k-1];
      assign p_rad  = rad[k-1];
      assign p_side = side[k-1];
    end

    // The partial remainder never exceeds twice the partial root.
    assign cat   = {p_rem[RW-3:0], p_rad[IN_W-1 -: 2]};
    assign trial = RW'({p_root, 2'b01});
    assign take  = (cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= take ? (cat - trial) : cat;
        root[k] <= {p_root[OW-2:0], take};
        rad[k]  <= {p_rad[IN_W-3:0], 2'b00};
        side[k] <= p_side;
      end
    end
  end

  assign out_valid = vld[OW-1];
  assign out_root  = root[OW-1];
  assign out_side  = side[OW-1];

endmodule

`default_nettype wire

FILE: rtl/ofd_div.sv
`default_nettype none

// Pipelined restoring divider: several magnitudes, each scaled up by the
// fraction bits, divided by one shared denominator. One quotient bit per
// stage; the quotient must fit in Q_W bits.
module ofd_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 17,
  parameter int LANES  = 3,
  parameter int SIDE_W = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [LANES-1:0][NUM_W-1:0] in_num,
  input  wire logic [DEN_W-1:0]            in_den,
  input  wire logic [SIDE_W-1:0]           in_side,
  output logic                             out_valid,
  output logic [LANES-1:0][Q_W-1:0]        out_quo,
  output logic [SIDE_W-1:0]                out_side
);

  localparam int DVD_W = NUM_W + ofd_pkg::OUT_FRAC_BITS;

  logic                        vld  [Q_W];
  logic [LANES-1:0][DEN_W-1:0] rem  [Q_W];
  logic [LANES-1:0][Q_W-1:0]   low  [Q_W];
  logic [LANES-1:0][Q_W-1:0]   quo  [Q_W];
  logic [DEN_W-1:0]            den  [Q_W];
  logic [SIDE_W-1:0]           side [Q_W];

  // Dividend split: high part seeds the remainder, low part is shifted in.
  logic [LANES-1:0][DEN_W-1:0] rem_init;
  logic [LANES-1:0][Q_W-1:0]   low_init;

  for (genvar l = 0; l < LANES; l++) begin : g_init
    logic [DVD_W-1:0] dvd;
    assign dvd         = {in_num[l], {ofd_pkg::OUT_FRAC_BITS{1'b0}}};
    assign rem_init[l] = DEN_W'(dvd >> Q_W);
    assign low_init[l] = dvd[Q_W-1:0];
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic                        p_vld;
    logic [LANES-1:0][DEN_W-1:0] p_rem;
    logic [LANES-1:0][Q_W-1:0]   p_low;
    logic [LANES-1:0][Q_W-1:0]   p_quo;
    logic [DEN_W-1:0]            p_den;
    logic [SIDE_W-1:0]           p_side;
    logic [LANES-1:0][DEN_W-1:0] n_rem;
    logic [LANES-1:0]            take;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = rem_init;
      assign p_low  = low_init;
      assign p_quo  = '0;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[k-1];
      assign p_rem  = rem[k-1];
      assign p_low  = low[k-1];
      assign p_quo  = quo[k-1];
      assign p_den  = den[k-1];
      assign p_side = side[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] cat;
      logic [DEN_W:0] dif;
      assign cat      = {p_rem[l], p_low[l][Q_W-1]};
      assign dif      = cat - {1'b0, p_den};
      assign take[l]  = (cat >= {1'b0, p_den});
      assign n_rem[l] = take[l] ? dif[DEN_W-1:0] : cat[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem[k][l] <= n_rem[l];
          low[k][l] <= {p_low[l][Q_W-2:0], 1'b0};
          quo[k][l] <= {p_quo[l][Q_W-2:0], take[l]};
        end
        den[k]  <= p_den;
        side[k] <= p_side;
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign out_quo   = quo[Q_W-1];
  assign out_side  = side[Q_W-1];

endmodule

`default_nettype wire

FILE: rtl/ofd_skid.sv
`default_nettype none

// Two-entry output buffer. The pipeline advances whenever a slot is free.
module ofd_skid #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [W-1:0] in_data,
  output logic              room,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   cnt;
  logic         push;
  logic         pop;

  assign room      = (cnt != 2'd2);
  assign push      = in_valid && room;
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/orthonormal_frame_from_direction.sv
// Channel   Handshake                       Payload
// input     s_axis_tvalid / s_axis_tready   s_axis_tdata: dir_x, dir_y, dir_z
// output    m_axis_tvalid / m_axis_tready   m_axis_tdata: nine rows, m_axis_tuser: invalid
//
// One item enters per cycle while the output buffer has a free slot; a
// result passes through the two square root pipelines (32 and 17 stages),
// the two divider pipelines (17 stages each), ten more register stages
// and the output buffer.
// Reset (rst, synchronous, active high) clears all valid bits and the
// output buffer; no item is held across reset.
// The whole pipeline stalls only when both output buffer slots are full.
`default_nettype none

`include "orthonormal_frame_from_direction_defines.svh"

module orthonormal_frame_from_direction (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // dir_x [31:0], dir_y [63:32], dir_z [95:64]
  input  wire logic [95:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // row0_x, row0_y, row0_z, row1_x, row1_y, row1_z, row2_x, row2_y, row2_z,
  // 18 bits each from bit 0 up, bits [167:162] zero
  output logic [167:0]      m_axis_tdata,
  // invalid
  output logic              m_axis_tuser
);

  localparam int F     = ofd_pkg::OUT_FRAC_BITS;
  localparam int DW    = ofd_pkg::DIR_W;
  localparam int RW    = ofd_pkg::ROW_W;
  localparam int QW    = F + 1;
  localparam int UMW   = F + 1;
  localparam int PW    = 2 * RW;
  localparam int DFW   = PW + 1;
  localparam int SQ1_W = 2 * DW;
  localparam int SQ2_W = 2 * F + 2;
  localparam int LU_W  = SQ2_W / 2;
  localparam int TD_W  = ((9 * RW + 7) / 8) * 8;
  localparam int S1_W  = 3 * DW + 4;
  localparam int S2_W  = 3 * RW + 3 * UMW + 4;
  localparam int D2_W  = 3 * RW + 5;

  localparam logic [RW-1:0]        ROW_ONE  = RW'(1) << F;
  localparam logic [RW-1:0]        ROW_MONE = RW'(0) - ROW_ONE;
  localparam logic signed [DFW-1:0] E_ONE   = DFW'(1) << (2 * F);
  localparam logic signed [DFW-1:0] SAT_HI  = DFW'((1 << (RW - 1)) - 1);
  localparam logic signed [DFW-1:0] SAT_LO  = -SAT_HI - DFW'(1);

  // Signed shift right by F that rounds toward zero.
  function automatic logic signed [DFW-1:0] shr_trunc(input logic signed [DFW-1:0] v);
    logic [DFW-1:0] mag;
    mag = v[DFW-1] ? (DFW'(0) - v) : v;
    mag = mag >> F;
    return v[DFW-1] ? $signed(DFW'(0) - mag) : $signed(mag);
  endfunction

  function automatic logic [RW-1:0] sat_row(input logic signed [DFW-1:0] v);
    logic signed [DFW-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return c[RW-1:0];
  endfunction

  logic en;
  assign s_axis_tready = en;

  // Stage A: input register.
  logic               a_vld;
  logic [2:0][DW-1:0] a_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d <= s_axis_tdata;
    end
  end

  // Stage B: squares of the components and their magnitudes.
  logic                  b_vld;
  logic [2:0][SQ1_W-2:0] b_sq;
  logic [2:0][DW-1:0]    b_mag;
  logic [2:0]            b_neg;
  logic signed [SQ1_W-1:0] b_sq_c [3];

  for (genvar k = 0; k < 3; k++) begin : g_bsq
    assign b_sq_c[k] = SQ1_W'($signed(a_d[k])) * SQ1_W'($signed(a_d[k]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        b_sq[k]  <= b_sq_c[k][SQ1_W-2:0];
        b_mag[k] <= a_d[k][DW-1] ? (DW'(0) - a_d[k]) : a_d[k];
        b_neg[k] <= a_d[k][DW-1];
      end
    end
  end

  // Stage C: squared length; a zero length marks the item invalid.
  logic               c_vld;
  logic [SQ1_W-1:0]   c_sum;
  logic               c_zero;
  logic [2:0][DW-1:0] c_mag;
  logic [2:0]         c_neg;
  logic [SQ1_W-1:0]   c_sum_c;

  assign c_sum_c = SQ1_W'(b_sq[0]) + SQ1_W'(b_sq[1]) + SQ1_W'(b_sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum  <= c_sum_c;
      c_zero <= (c_sum_c == '0);
      c_mag  <= b_mag;
      c_neg  <= b_neg;
    end
  end

  // Length of the direction.
  logic               d_vld;
  logic [DW-1:0]      d_len;
  logic [S1_W-1:0]    d_side;
  logic [2:0][DW-1:0] d_mag;
  logic [2:0]         d_neg;
  logic               d_zero;

  ofd_sqrt #(
    .IN_W   (SQ1_W),
    .SIDE_W (S1_W)
  ) u_len_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_vld),
    .in_rad    (c_sum),
    .in_side   ({c_zero, c_neg, c_mag}),
    .out_valid (d_vld),
    .out_root  (d_len),
    .out_side  (d_side)
  );

  assign d_mag  = d_side[3*DW-1:0];
  assign d_neg  = d_side[3*DW+2:3*DW];
  assign d_zero = d_side[3*DW+3];

  // Row 0 magnitudes: |d| * 2^F / len.
  logic               q_vld;
  logic [2:0][QW-1:0] q_quo;
  logic [3:0]         q_side;

  ofd_div #(
    .NUM_W  (DW),
    .DEN_W  (DW),
    .Q_W    (QW),
    .LANES  (3),
    .SIDE_W (4)
  ) u_row0_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_vld),
    .in_num    (d_mag),
    .in_den    (d_len),
    .in_side   ({d_zero, d_neg}),
    .out_valid (q_vld),
    .out_quo   (q_quo),
    .out_side  (q_side)
  );

  // Stage E: signed row 0.
  logic               e_vld;
  logic [2:0][RW-1:0] e_r;
  logic               e_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e_r[k] <= q_side[k] ? (RW'(0) - RW'(q_quo[k])) : RW'(q_quo[k]);
      end
      e_zero <= q_side[3];
    end
  end

  // Stage F: pick the reference axis. A row 0 of exactly (0, +-1, 0) takes
  // the x axis, anything else the y axis. Then form sp * r_k.
  logic               f_vld;
  logic [2:0][PW-1:0] f_p;
  logic [2:0][RW-1:0] f_r;
  logic               f_ax;
  logic               f_zero;
  logic               ax_c;
  logic [RW-1:0]      ra_c;
  logic signed [PW-1:0] f_p_c [3];

  assign ax_c = (e_r[0] == '0) && (e_r[2] == '0) &&
                ((e_r[1] == ROW_ONE) || (e_r[1] == ROW_MONE));
  assign ra_c = ax_c ? e_r[0] : e_r[1];

  for (genvar k = 0; k < 3; k++) begin : g_fp
    assign f_p_c[k] = PW'($signed(ra_c)) * PW'($signed(e_r[k]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        f_p[k] <= f_p_c[k];
      end
      f_r    <= e_r;
      f_ax   <= ax_c;
      f_zero <= e_zero;
    end
  end

  // Stage G: u_k = (e_k * 2^2F - sp * r_k) / 2^F.
  logic               g_vld;
  logic [2:0][RW-1:0] g_u;
  logic [2:0][RW-1:0] g_r;
  logic               g_zero;
  logic signed [DFW-1:0] g_dif_c [3];

  assign g_dif_c[0] = (f_ax ? E_ONE : DFW'(0)) - DFW'($signed(f_p[0]));
  assign g_dif_c[1] = (f_ax ? DFW'(0) : E_ONE) - DFW'($signed(f_p[1]));
  assign g_dif_c[2] = DFW'(0) - DFW'($signed(f_p[2]));

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        g_u[k] <= RW'(shr_trunc(g_dif_c[k]));
      end
      g_r    <= f_r;
      g_zero <= f_zero;
    end
  end

  // Stage H: squares of u and their magnitudes.
  logic                  h_vld;
  logic [2:0][SQ2_W-2:0] h_sq;
  logic [2:0][UMW-1:0]   h_umag;
  logic [2:0]            h_uneg;
  logic [2:0][RW-1:0]    h_r;
  logic                  h_zero;
  logic signed [PW-1:0]  h_sq_c [3];
  logic [RW-1:0]         h_mag_c [3];

  for (genvar k = 0; k < 3; k++) begin : g_hsq
    assign h_sq_c[k]  = PW'($signed(g_u[k])) * PW'($signed(g_u[k]));
    assign h_mag_c[k] = g_u[k][RW-1] ? (RW'(0) - g_u[k]) : g_u[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (en) begin
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        h_sq[k]   <= h_sq_c[k][SQ2_W-2:0];
        h_umag[k] <= h_mag_c[k][UMW-1:0];
        h_uneg[k] <= g_u[k][RW-1];
      end
      h_r    <= g_r;
      h_zero <= g_zero;
    end
  end

  // Stage I: squared length of u.
  logic                i_vld;
  logic [SQ2_W-1:0]    i_sum;
  logic [2:0][UMW-1:0] i_umag;
  logic [2:0]          i_uneg;
  logic [2:0][RW-1:0]  i_r;
  logic                i_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else if (en) begin
      i_vld <= h_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_sum  <= SQ2_W'(h_sq[0]) + SQ2_W'(h_sq[1]) + SQ2_W'(h_sq[2]);
      i_umag <= h_umag;
      i_uneg <= h_uneg;
      i_r    <= h_r;
      i_zero <= h_zero;
    end
  end

  // Length of u.
  logic                m_vld;
  logic [LU_W-1:0]     m_lu;
  logic [S2_W-1:0]     m_side;
  logic [2:0][RW-1:0]  m_r;
  logic [2:0][UMW-1:0] m_umag;
  logic [2:0]          m_uneg;
  logic                m_zero;

  ofd_sqrt #(
    .IN_W   (SQ2_W),
    .SIDE_W (S2_W)
  ) u_lu_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (i_vld),
    .in_rad    (i_sum),
    .in_side   ({i_zero, i_uneg, i_umag, i_r}),
    .out_valid (m_vld),
    .out_root  (m_lu),
    .out_side  (m_side)
  );

  assign m_r    = m_side[3*RW-1:0];
  assign m_umag = m_side[3*RW+3*UMW-1:3*RW];
  assign m_uneg = m_side[3*RW+3*UMW+2:3*RW+3*UMW];
  assign m_zero = m_side[3*RW+3*UMW+3];

  // Row 1 magnitudes: |u| * 2^F / lu.
  logic               n_vld;
  logic [2:0][QW-1:0] n_quo;
  logic [D2_W-1:0]    n_side;

  ofd_div #(
    .NUM_W  (UMW),
    .DEN_W  (LU_W),
    .Q_W    (QW),
    .LANES  (3),
    .SIDE_W (D2_W)
  ) u_row1_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m_vld),
    .in_num    (m_umag),
    .in_den    (m_lu),
    .in_side   ({(m_lu == '0), m_zero, m_uneg, m_r}),
    .out_valid (n_vld),
    .out_quo   (n_quo),
    .out_side  (n_side)
  );

  // Stage J: signed row 1. A zero-length u leaves rows 1 and 2 at zero.
  logic               j_vld;
  logic [2:0][RW-1:0] j_s;
  logic [2:0][RW-1:0] j_r;
  logic               j_zero;
  logic [2:0]         n_uneg;
  logic               n_luzero;

  assign n_uneg   = n_side[3*RW+2:3*RW];
  assign n_luzero = n_side[3*RW+4];

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else if (en) begin
      j_vld <= n_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (n_luzero) begin
          j_s[k] <= '0;
        end else begin
          j_s[k] <= n_uneg[k] ? (RW'(0) - RW'(n_quo[k])) : RW'(n_quo[k]);
        end
      end
      j_r    <= n_side[3*RW-1:0];
      j_zero <= n_side[3*RW+3];
    end
  end

  // Stage K: the six partial products of the cross product.
  logic               k_vld;
  logic [5:0][PW-1:0] k_p;
  logic [2:0][RW-1:0] k_r;
  logic [2:0][RW-1:0] k_s;
  logic               k_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else if (en) begin
      k_vld <= j_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_p[0] <= PW'($signed(j_r[1])) * PW'($signed(j_s[2]));
      k_p[1] <= PW'($signed(j_r[2])) * PW'($signed(j_s[1]));
      k_p[2] <= PW'($signed(j_r[2])) * PW'($signed(j_s[0]));
      k_p[3] <= PW'($signed(j_r[0])) * PW'($signed(j_s[2]));
      k_p[4] <= PW'($signed(j_r[0])) * PW'($signed(j_s[1]));
      k_p[5] <= PW'($signed(j_r[1])) * PW'($signed(j_s[0]));
      k_r    <= j_r;
      k_s    <= j_s;
      k_zero <= j_zero;
    end
  end

  // Row 2 differences, rescaled and saturated, then packed for the buffer.
  logic [2:0][RW-1:0] l_c;
  logic [TD_W-1:0]    l_data;

  for (genvar k = 0; k < 3; k++) begin : g_cross
    assign l_c[k] = sat_row(shr_trunc(DFW'($signed(k_p[2*k])) -
                                      DFW'($signed(k_p[2*k+1]))));
  end

  assign l_data = k_zero ? '0 : TD_W'({l_c, k_s, k_r});

  ofd_skid #(
    .W (TD_W + 1)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (k_vld),
    .in_data   ({k_zero, l_data}),
    .room      (en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  ({m_axis_tuser, m_axis_tdata})
  );

  // Checks on delivered results and on the stall path.
  logic signed [RW-1:0] chk_r0x;
  assign chk_r0x = $signed(m_axis_tdata[RW-1:0]);

  `OFD_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "invalid item carries nonzero rows")
  `OFD_ASSERT_NOW(a_stall_has_output, !s_axis_tready, m_axis_tvalid, "pipeline stalled with empty output buffer")
  `OFD_ASSERT_NOW(a_row0_unit, m_axis_tvalid, (chk_r0x <= $signed(ROW_ONE)) && (chk_r0x >= $signed(ROW_MONE)), "row 0 component exceeds unit magnitude")

endmodule

`default_nettype wire

FILE: tb/ofd_frame_checker.sv
`default_nettype none

module ofd_frame_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [167:0] m_axis_tdata,
  input  wire logic         m_axis_tuser,
  output int                fail_count,
  output int                pending_frames
);

  typedef struct packed {
    logic                        invalid;
    logic [9*ofd_pkg::ROW_W-1:0] rows;
  } frame_t;

  frame_t frame_queue[$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint num_sign(longint v, longint unsigned q);
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint scaled_quot(longint num, longint unsigned den);
    longint unsigned q;
    q = (magnitude(num) << ofd_pkg::OUT_FRAC_BITS) / den;
    return num_sign(num, q);
  endfunction

  function automatic longint drop_frac(longint v);
    longint unsigned q;
    q = magnitude(v) >> ofd_pkg::OUT_FRAC_BITS;
    return num_sign(v, q);
  endfunction

  function automatic logic [ofd_pkg::ROW_W-1:0] clamp_row(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[ofd_pkg::ROW_W-1:0];
  endfunction

  function automatic frame_t build_frame(logic [95:0] din);
    longint d[3], r[3], u[3], s[3], c[3];
    longint one;
    longint unsigned sum, len, lu;
    int a;
    frame_t f;
    one = longint'(1) << ofd_pkg::OUT_FRAC_BITS;
    f = '0;
    for (int k = 0; k < 3; k++)
      d[k] = longint'($signed(din[k*ofd_pkg::DIR_W +: ofd_pkg::DIR_W]));
    sum = 0;
    for (int k = 0; k < 3; k++) sum += d[k] * d[k];
    if (sum == 0) begin
      f.invalid = 1'b1;
      return f;
    end
    len = root_floor(sum);
    for (int k = 0; k < 3; k++) r[k] = scaled_quot(d[k], len);
    // A row 0 of exactly (0, +-1, 0) takes the x axis as reference.
    a = (r[0] == 0 && r[2] == 0 && (r[1] == one || r[1] == -one)) ? 0 : 1;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      u[k] = drop_frac(((k == a) ? (longint'(1) << (2*ofd_pkg::OUT_FRAC_BITS)) : 0) -
                       r[a] * r[k]);
      sum += u[k] * u[k];
    end
    lu = root_floor(sum);
    for (int k = 0; k < 3; k++) s[k] = (lu != 0) ? scaled_quot(u[k], lu) : 0;
    c[0] = drop_frac(r[1] * s[2] - r[2] * s[1]);
    c[1] = drop_frac(r[2] * s[0] - r[0] * s[2]);
    c[2] = drop_frac(r[0] * s[1] - r[1] * s[0]);
    for (int k = 0; k < 3; k++) begin
      f.rows[k*ofd_pkg::ROW_W +: ofd_pkg::ROW_W]     = clamp_row(r[k]);
      f.rows[(3+k)*ofd_pkg::ROW_W +: ofd_pkg::ROW_W] = clamp_row(s[k]);
      f.rows[(6+k)*ofd_pkg::ROW_W +: ofd_pkg::ROW_W] = clamp_row(c[k]);
    end
    return f;
  endfunction

  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) frame_queue.push_back(build_frame(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected frame %h", m_axis_tdata);
        end else begin
          want = frame_queue.pop_front();
          if (want.rows !== m_axis_tdata[9*ofd_pkg::ROW_W-1:0] ||
              m_axis_tdata[167:162] !== 6'd0 || want.invalid !== m_axis_tuser) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %h/%b got %h/%b", want.rows, want.invalid,
                       m_axis_tdata, m_axis_tuser);
          end
        end
      end
    end
    pending_frames <= frame_queue.size();
  end
endmodule

`default_nettype wire

FILE: tb/orthonormal_frame_from_direction_test.sv
`default_nettype none

module orthonormal_frame_from_direction_test;
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           fail_count;
  int           pending_frames;
  int           send_idle_pct = 21;
  int           recv_idle_pct = 85;

  orthonormal_frame_from_direction u_dut (.*);
  ofd_frame_checker u_check (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [31:0] pick_component();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(7) - 3;
      4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Presents one item and holds it until it is accepted.
  task automatic send_dir(logic [95:0] dir);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dir;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    logic [95:0] edge_dirs[$];
    int unsigned n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: zero length, the axes, the y axis switch and field extremes.
    edge_dirs = '{96'd0, {32'd0, 32'd0, 32'h0001_0000}, {32'd0, 32'h0001_0000, 32'd0},
                  {32'd0, 32'hffff_0000, 32'd0}, {32'h0001_0000, 32'd0, 32'd0},
                  {32'd0, 32'h7fff_ffff, 32'd0}, {32'd0, 32'h8000_0000, 32'd0},
                  {32'd0, 32'h7fff_ffff, 32'd1}, {32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                  {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}, {32'd1, 32'd1, 32'd1},
                  {32'hffff_ffff, 32'd0, 32'd0}, {32'h8000_0000, 32'h7fff_ffff, 32'd5},
                  {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}, {32'd0, 32'd1, 32'd0}};
    foreach (edge_dirs[i]) send_dir(edge_dirs[i]);
    // Drain so that the sender waits for every frame once.
    s_axis_tvalid <= 1'b0;
    while (pending_frames != 0) @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 21 : 0;
      n = (phase == 2) ? 700 : 600;
      repeat (n) send_dir({pick_component(), pick_component(), pick_component()});
    end
    s_axis_tvalid <= 1'b0;
    while (pending_frames != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/ofd_pkg.sv
rtl/ofd_sqrt.sv
rtl/ofd_div.sv
rtl/ofd_skid.sv
rtl/orthonormal_frame_from_direction.sv
tb/ofd_frame_checker.sv
tb/orthonormal_frame_from_direction_test.sv
